// ===== sv/clcs_pkg.sv =====
// Shared types, constants and per-word helper functions for the compressed size unit.
package clcs_pkg;

    // compression_mode register codes
    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_BDI  = 2'd1,
        MODE_FPC  = 2'd2,
        MODE_MIN  = 2'd3
    } t_mode;

    // register index of compression_mode (paddr[2])
    localparam logic REG_MODE_IDX = 1'b0;

    // base-delta cases: 8/1, 8/2, 8/4, 4/1, 4/2, 2/1
    localparam int NUM_CASES = 6;
    localparam logic [63:0] CASE_LIMIT [NUM_CASES] = '{
        64'h0000_0000_0000_00FF, 64'h0000_0000_0000_FFFF, 64'h0000_0000_FFFF_FFFF,
        64'h0000_0000_0000_00FF, 64'h0000_0000_0000_FFFF, 64'h0000_0000_0000_00FF
    };
    localparam int CASE_ELEM  [NUM_CASES] = '{8, 8, 8, 4, 4, 2};
    localparam int CASE_DELTA [NUM_CASES] = '{1, 2, 4, 1, 2, 1};

    // one base-delta case while a line streams in
    typedef struct packed {
        logic        found;
        logic        covered;
        logic [63:0] base;
    } t_bd_state;

    // what is left of a finished line for the size decision
    typedef struct packed {
        t_mode                mode;
        logic                 all_zero;
        logic                 same8;
        logic                 same4;
        logic [NUM_CASES-1:0] covered;
        logic [7:0]           pattern_sum;
    } t_line_summary;

    // |a - b| on 64-bit two's complement
    function automatic logic [63:0] abs_diff64(logic [63:0] a, logic [63:0] b);
        logic [63:0] d;
        d = a - b;
        return d[63] ? (64'd0 - d) : d;
    endfunction

    // fold one element into a base-delta case
    function automatic t_bd_state bd_take(t_bd_state s, logic [63:0] v, logic [63:0] lim);
        logic      near;
        t_bd_state r;
        near = abs_diff64(64'd0, v) <= lim;
        r    = s;
        if (!s.found && !near) begin
            r.found = 1'b1;
            r.base  = v;
        end
        if (!near && !(r.found && (abs_diff64(r.base, v) <= lim))) begin
            r.covered = 1'b0;
        end
        return r;
    endfunction

    // FPC pattern size of one 32-bit word, first match wins
    function automatic logic [2:0] fpc_size(logic [31:0] v);
        logic [31:0] mag;
        mag = v[31] ? (32'd0 - v) : v;
        if (v == 32'd0) begin
            return 3'd1;
        end else if (mag <= 32'h0000_00FF) begin
            return 3'd1;
        end else if (mag <= 32'h0000_FFFF) begin
            return 3'd2;
        end else if (v[15:0] == 16'd0) begin
            return 3'd2;
        end else if ((v[15:8] == 8'd0) && (v[31:24] == 8'd0)) begin
            return 3'd2;
        end else if ((v[15:8] == v[7:0]) && (v[23:16] == v[7:0]) && (v[31:24] == v[7:0])) begin
            return 3'd1;
        end else begin
            return 3'd4;
        end
    endfunction

endpackage

// ===== sv/clcs_line_acc.sv =====
// Input word register and per-line running checks (zero, repeat, base-delta, FPC sum).
module clcs_line_acc #(
    parameter int LINE_WORDS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic [63:0]             i_line_word,
    output logic                    o_in_stall,
    input  clcs_pkg::t_mode         i_mode,
    input  logic                    i_sum_free,
    output logic                    o_sum_load,
    output clcs_pkg::t_line_summary o_summary
);

    localparam int IDX_W = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_WORDS - 1);

    logic                              r_in_valid;
    logic [63:0]                       r_word;
    logic [IDX_W-1:0]                  r_word_index;
    logic                              r_all_zero;
    logic [63:0]                       r_first;
    logic                              r_same8;
    logic                              r_same4;
    logic [clcs_pkg::NUM_CASES-1:0]    r_found;
    logic [clcs_pkg::NUM_CASES-1:0]    r_covered;
    logic [63:0]                       r_base [clcs_pkg::NUM_CASES];
    logic [7:0]                        r_psum;

    logic                              w_last;
    logic                              w_move;
    logic [63:0]                       w_first;
    logic                              n_all_zero;
    logic                              n_same8;
    logic                              n_same4;
    clcs_pkg::t_bd_state               n_bd [clcs_pkg::NUM_CASES];
    logic [7:0]                        n_psum;

    assign w_last     = (r_word_index == LAST_IDX);
    assign w_move     = r_in_valid && (!w_last || i_sum_free);
    assign o_in_stall = r_in_valid && !w_move;
    assign o_sum_load = w_move && w_last;

    // word 0 is its own first element
    assign w_first    = (r_word_index == '0) ? r_word : r_first;
    assign n_all_zero = r_all_zero && (r_word == 64'd0);
    assign n_same8    = r_same8 && (r_word == w_first);
    assign n_same4    = r_same4 && (r_word[31:0] == w_first[31:0])
                                && (r_word[63:32] == w_first[31:0]);
    assign n_psum     = r_psum + 8'(clcs_pkg::fpc_size(r_word[31:0]))
                               + 8'(clcs_pkg::fpc_size(r_word[63:32]));

    // elements of one word go through a case in address order
    always_comb begin
        for (int k = 0; k < clcs_pkg::NUM_CASES; k++) begin
            n_bd[k].found   = r_found[k];
            n_bd[k].covered = r_covered[k];
            n_bd[k].base    = r_base[k];
            if (clcs_pkg::CASE_ELEM[k] == 8) begin
                n_bd[k] = clcs_pkg::bd_take(n_bd[k], r_word, clcs_pkg::CASE_LIMIT[k]);
            end else if (clcs_pkg::CASE_ELEM[k] == 4) begin
                for (int j = 0; j < 2; j++) begin
                    n_bd[k] = clcs_pkg::bd_take(n_bd[k], {32'd0, r_word[32*j +: 32]},
                                                clcs_pkg::CASE_LIMIT[k]);
                end
            end else begin
                for (int j = 0; j < 4; j++) begin
                    n_bd[k] = clcs_pkg::bd_take(n_bd[k], {48'd0, r_word[16*j +: 16]},
                                                clcs_pkg::CASE_LIMIT[k]);
                end
            end
        end
    end

    always_comb begin
        o_summary.mode        = i_mode;
        o_summary.all_zero    = n_all_zero;
        o_summary.same8       = n_same8;
        o_summary.same4       = n_same4;
        o_summary.pattern_sum = n_psum;
        for (int k = 0; k < clcs_pkg::NUM_CASES; k++) begin
            o_summary.covered[k] = n_bd[k].covered;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_word_index <= '0;
            r_all_zero   <= 1'b1;
            r_same8      <= 1'b1;
            r_same4      <= 1'b1;
            r_found      <= '0;
            r_covered    <= '1;
            r_psum       <= 8'd0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_move) begin
                if (w_last) begin
                    r_word_index <= '0;
                    r_all_zero   <= 1'b1;
                    r_same8      <= 1'b1;
                    r_same4      <= 1'b1;
                    r_found      <= '0;
                    r_covered    <= '1;
                    r_psum       <= 8'd0;
                end else begin
                    r_word_index <= r_word_index + IDX_W'(1);
                    r_all_zero   <= n_all_zero;
                    r_same8      <= n_same8;
                    r_same4      <= n_same4;
                    r_psum       <= n_psum;
                    for (int k = 0; k < clcs_pkg::NUM_CASES; k++) begin
                        r_found[k]   <= n_bd[k].found;
                        r_covered[k] <= n_bd[k].covered;
                    end
                end
            end
        end
    end

    // payload, read only once qualified by index or found flags
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_word <= i_line_word;
        end
        if (w_move && (r_word_index == '0)) begin
            r_first <= r_word;
        end
        if (w_move) begin
            for (int k = 0; k < clcs_pkg::NUM_CASES; k++) begin
                r_base[k] <= n_bd[k].base;
            end
        end
    end

    // line state restarts after the last word
    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && w_last) |=> (r_word_index == '0) && r_all_zero && (r_found == '0))
        else $error("line state not cleared after last word");

    // coverage flags only drop within a line
    a_covered_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && !w_last) |=> ((r_covered & ~$past(r_covered)) == '0))
        else $error("base-delta coverage flag rose mid-line");

endmodule

// ===== sv/clcs_size_sel.sv =====
// Finished-line register, BDI/FPC size decision and output register.
module clcs_size_sel #(
    parameter int LINE_BYTES = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_sum_load,
    input  clcs_pkg::t_line_summary i_summary,
    output logic                    o_sum_free,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [7:0]              o_compressed_bytes
);

    localparam logic [7:0] LINE_SIZE = 8'(LINE_BYTES);
    localparam logic [7:0] TAG_BYTES = 8'(((LINE_BYTES / 8) * 2 * 3) / 8);

    logic                           r_sum_valid;
    clcs_pkg::t_line_summary        r_sum;
    logic                           r_out_valid;
    logic [7:0]                     r_out_bytes;

    logic                           w_out_free;
    logic [7:0]                     w_case_size [clcs_pkg::NUM_CASES];
    logic [7:0]                     w_bdi;
    logic [8:0]                     w_fpc_raw;
    logic [7:0]                     w_fpc;
    logic [7:0]                     n_bytes;

    assign w_out_free         = !r_out_valid || !i_out_stall;
    assign o_sum_free         = !r_sum_valid || w_out_free;
    assign o_out_valid        = r_out_valid;
    assign o_compressed_bytes = r_out_bytes;

    for (genvar k = 0; k < clcs_pkg::NUM_CASES; k++) begin : g_case
        localparam logic [7:0] SIZE = 8'(clcs_pkg::CASE_DELTA[k]
                                         * (LINE_BYTES / clcs_pkg::CASE_ELEM[k])
                                         + 2 * clcs_pkg::CASE_ELEM[k]);
        assign w_case_size[k] = r_sum.covered[k] ? SIZE : LINE_SIZE;
    end

    always_comb begin
        w_bdi = LINE_SIZE;
        if (r_sum.same8 && (w_bdi > 8'd8)) begin
            w_bdi = 8'd8;
        end
        if (r_sum.same4 && (w_bdi > 8'd4)) begin
            w_bdi = 8'd4;
        end
        for (int k = 0; k < clcs_pkg::NUM_CASES; k++) begin
            if (w_case_size[k] < w_bdi) begin
                w_bdi = w_case_size[k];
            end
        end
        // an all-zero line beats every other encoding
        if (r_sum.all_zero) begin
            w_bdi = 8'd1;
        end
    end

    assign w_fpc_raw = {1'b0, r_sum.pattern_sum} + {1'b0, TAG_BYTES};
    assign w_fpc     = (w_fpc_raw < {1'b0, LINE_SIZE}) ? w_fpc_raw[7:0] : LINE_SIZE;

    always_comb begin
        unique case (r_sum.mode)
            clcs_pkg::MODE_NONE: n_bytes = LINE_SIZE;
            clcs_pkg::MODE_BDI:  n_bytes = w_bdi;
            clcs_pkg::MODE_FPC:  n_bytes = w_fpc;
            clcs_pkg::MODE_MIN:  n_bytes = (w_bdi <= w_fpc) ? w_bdi : w_fpc;
            default:             n_bytes = LINE_SIZE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_sum_free) begin
                r_sum_valid <= i_sum_load;
            end
            if (w_out_free) begin
                r_out_valid <= r_sum_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sum_load && o_sum_free) begin
            r_sum <= i_summary;
        end
        if (r_sum_valid && w_out_free) begin
            r_out_bytes <= n_bytes;
        end
    end

    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_compressed_bytes != 8'd0) && (o_compressed_bytes <= LINE_SIZE))
        else $error("compressed size out of range");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sum_load |-> o_sum_free)
        else $error("finished line pushed into a full summary stage");

endmodule

// ===== sv/cache_line_compressed_size_unit.sv =====
// Top level of the cache line compressed size unit: mode register and pipeline.
//
// Streams a cache line of LINE_BYTES/8 little-endian 64-bit words, one word per
// transfer, and after the last word delivers the estimated compressed size of
// the line in bytes (1..LINE_BYTES). compression_mode (APB address 0, bits 1:0,
// reset BDI) picks the estimate: 0 uncompressed, 1 base-delta-immediate, 2
// frequent pattern compression, 3 the smaller of the two. Every estimate is
// kept up word by word, so no line buffer is needed. The unit takes one word
// every cycle unless the input is stalled: each word passes an input register,
// then an update of the running line checks; the last word additionally loads
// a finished-line register whose size decision lands in the output register.
// The input stall follows the output stall combinationally through the three
// registers, so with the output stalled the unit still absorbs the words of
// the next line until it holds two finished results and one pending last word.
// Write the mode only while no line is in flight.
module cache_line_compressed_size_unit #(
    parameter int LINE_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // line words
    input  logic        i_in_valid,
    input  logic [63:0] i_line_word,
    output logic        o_in_stall,
    // compressed size
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_compressed_bytes,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LINE_WORDS = LINE_BYTES / 8;

    clcs_pkg::t_mode         r_mode;
    logic                    w_cfg_write;
    logic                    w_sum_free;
    logic                    w_sum_load;
    clcs_pkg::t_line_summary w_summary;

    // register access: zero-wait APB, one register
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && (paddr[2] == clcs_pkg::REG_MODE_IDX);
    assign prdata      = (paddr[2] == clcs_pkg::REG_MODE_IDX) ? {30'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= clcs_pkg::MODE_BDI;
        end else if (w_cfg_write) begin
            r_mode <= clcs_pkg::t_mode'(pwdata[1:0]);
        end
    end

    // word register + running per-line checks
    clcs_line_acc #(
        .LINE_WORDS (LINE_WORDS)
    ) u_line_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_line_word (i_line_word),
        .o_in_stall  (o_in_stall),
        .i_mode      (r_mode),
        .i_sum_free  (w_sum_free),
        .o_sum_load  (w_sum_load),
        .o_summary   (w_summary)
    );

    // size decision + output register
    clcs_size_sel #(
        .LINE_BYTES (LINE_BYTES)
    ) u_size_sel (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_sum_load         (w_sum_load),
        .i_summary          (w_summary),
        .o_sum_free         (w_sum_free),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_compressed_bytes (o_compressed_bytes)
    );

    a_mode_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_write |=> (r_mode == clcs_pkg::t_mode'($past(pwdata[1:0]))))
        else $error("compression_mode write lost");

endmodule

// ===== test/cache_line_compressed_size_unit_test.sv =====
// Self-checking testbench for cache_line_compressed_size_unit: directed lines, then random lines.
module cache_line_compressed_size_unit_test;

    // ------------------------------------------------------------------
    // Sizes and limits
    // ------------------------------------------------------------------
    localparam int LINE_BYTES  = 64;
    localparam int LINE_WORDS  = LINE_BYTES / 8;
    localparam int LINE_BITS   = LINE_BYTES * 8;
    localparam int LINE_HALVES = LINE_WORDS * 2;    // 32-bit words per line

    // Register byte addresses: mode is register 0 (paddr[2] clear); any address with paddr[2] set must be ignored.
    localparam logic [2:0] MODE_ADDR  = 3'd0;
    localparam logic [2:0] SPARE_ADDR = 3'd4;

    // Leave some margin after the last result before touching the mode register
    // or ending the run.
    localparam int SETTLE_CYCLES = 8;

    // Long receiver hold-off used to fill the unit and back-pressure the input.
    localparam int LONG_HOLD = 300;

    // Watchdog on cycles with no transfer on either side. The longest quiet
    // stretch in a correct run is the long hold-off once the unit has filled,
    // or a random stall streak at 47 percent receiver idling.
    localparam int WATCHDOG_LIMIT = 3000;

    // Random part: idle phases x mode segments x lines per segment.
    localparam int PHASES        = 3;
    localparam int SEGMENTS      = 4;
    localparam int SEGMENT_LINES = 20;
    localparam int SEND_IDLE_PCT [PHASES] = '{33, 47, 0};
    localparam int RECV_IDLE_PCT [PHASES] = '{47, 33, 0};

    // Base-delta cases in the order 8/1, 8/2, 8/4, 4/1, 4/2, 2/1.
    localparam int DELTA_CASES = 6;
    localparam logic [63:0] SPAN_LIMIT [DELTA_CASES] = '{
        64'h0000_0000_0000_00FF, 64'h0000_0000_0000_FFFF, 64'h0000_0000_FFFF_FFFF,
        64'h0000_0000_0000_00FF, 64'h0000_0000_0000_FFFF, 64'h0000_0000_0000_00FF
    };
    localparam int ELEM_BYTES  [DELTA_CASES] = '{8, 8, 8, 4, 4, 2};
    localparam int DELTA_BYTES [DELTA_CASES] = '{1, 2, 4, 1, 2, 1};

    // ------------------------------------------------------------------
    // Directed lines. A row's mode is applied at the start of its line. Only
    // sizes that are obvious are typed in; the rest come from the predictor.
    // ------------------------------------------------------------------
    typedef struct packed {
        clcs_pkg::t_mode mode;
        logic [63:0]     word;
        logic            typed;
        logic [7:0]      size;
    } t_dir_row;

    localparam int DIRECTED_ROWS = 4 * LINE_WORDS;
    localparam t_dir_row DIRECTED [DIRECTED_ROWS] = '{
        // BDI straight out of reset, all-zero line -> 1 byte
        '{clcs_pkg::MODE_BDI, 64'h0000_0000_0000_0000, 1'b1, 8'd1},
        '{clcs_pkg::MODE_BDI, 64'h0000_0000_0000_0000, 1'b1, 8'd1},
        '{clcs_pkg::MODE_BDI, 64'h0000_0000_0000_0000, 1'b1, 8'd1},
        '{clcs_pkg::MODE_BDI, 64'h0000_0000_0000_0000, 1'b1, 8'd1},
        '{clcs_pkg::MODE_BDI, 64'h0000_0000_0000_0000, 1'b1, 8'd1},
        '{clcs_pkg::MODE_BDI, 64'h0000_0000_0000_0000, 1'b1, 8'd1},
        '{clcs_pkg::MODE_BDI, 64'h0000_0000_0000_0000, 1'b1, 8'd1},
        '{clcs_pkg::MODE_BDI, 64'h0000_0000_0000_0000, 1'b1, 8'd1},
        // uncompressed, all-ones line -> full line size
        '{clcs_pkg::MODE_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'd64},
        '{clcs_pkg::MODE_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'd64},
        '{clcs_pkg::MODE_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'd64},
        '{clcs_pkg::MODE_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'd64},
        '{clcs_pkg::MODE_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'd64},
        '{clcs_pkg::MODE_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'd64},
        '{clcs_pkg::MODE_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'd64},
        '{clcs_pkg::MODE_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'd64},
        // FPC: every pattern rule, with negative and boundary magnitudes
        '{clcs_pkg::MODE_FPC, 64'h0000_00FF_0000_0000, 1'b0, 8'd0},
        '{clcs_pkg::MODE_FPC, 64'hFFFF_FF01_FFFF_FF00, 1'b0, 8'd0},
        '{clcs_pkg::MODE_FPC, 64'h0000_FFFF_FFFF_0000, 1'b0, 8'd0},
        '{clcs_pkg::MODE_FPC, 64'h00AB_00CD_ABAB_ABAB, 1'b0, 8'd0},
        '{clcs_pkg::MODE_FPC, 64'h8000_0000_DEAD_BEEF, 1'b0, 8'd0},
        '{clcs_pkg::MODE_FPC, 64'h7FFF_FFFF_0001_0000, 1'b0, 8'd0},
        '{clcs_pkg::MODE_FPC, 64'h1234_5678_0000_0100, 1'b0, 8'd0},
        '{clcs_pkg::MODE_FPC, 64'hFFFF_FFFF_8000_0001, 1'b0, 8'd0},
        // smaller of both: 8/1 base-delta, deltas on both sides of the base
        '{clcs_pkg::MODE_MIN, 64'h1000_0000_0000_0000, 1'b0, 8'd0},
        '{clcs_pkg::MODE_MIN, 64'h1000_0000_0000_007F, 1'b0, 8'd0},
        '{clcs_pkg::MODE_MIN, 64'h0FFF_FFFF_FFFF_FF01, 1'b0, 8'd0},
        '{clcs_pkg::MODE_MIN, 64'h0000_0000_0000_00FF, 1'b0, 8'd0},
        '{clcs_pkg::MODE_MIN, 64'hFFFF_FFFF_FFFF_FF01, 1'b0, 8'd0},
        '{clcs_pkg::MODE_MIN, 64'h1000_0000_0000_0080, 1'b0, 8'd0},
        '{clcs_pkg::MODE_MIN, 64'h0000_0000_0000_0000, 1'b0, 8'd0},
        '{clcs_pkg::MODE_MIN, 64'h1000_0000_0000_00FF, 1'b0, 8'd0}
    };

    // ------------------------------------------------------------------
    // DUT signals; every input is known from time zero
    // ------------------------------------------------------------------
    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        i_in_valid         = 1'b0;
    logic [63:0] i_line_word        = 64'd0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        i_out_stall        = 1'b0;
    logic [7:0]  o_compressed_bytes;
    logic        psel               = 1'b0;
    logic        penable            = 1'b0;
    logic        pwrite             = 1'b0;
    logic [2:0]  paddr              = 3'd0;
    logic [31:0] pwdata             = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    cache_line_compressed_size_unit #(
        .LINE_BYTES(LINE_BYTES)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_line_word        (i_line_word),
        .o_in_stall         (o_in_stall),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_compressed_bytes (o_compressed_bytes),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Size predictor: running line checks, updated per accepted word
    // ------------------------------------------------------------------
    clcs_pkg::t_mode        mode_shadow = clcs_pkg::MODE_BDI;
    int                     words_taken = 0;
    logic                   line_zero   = 1'b1;
    logic [63:0]            lead_word   = 64'd0;
    logic                   same8       = 1'b1;
    logic                   same4       = 1'b1;
    logic [DELTA_CASES-1:0] base_set    = '0;
    logic [DELTA_CASES-1:0] fits        = '1;
    logic [63:0]            base_of [DELTA_CASES];
    logic [7:0]             pattern_sum = 8'd0;

    logic [7:0] expected_sizes [$];   // one entry per line in flight
    int         failures = 0;

    // stimulus knobs, set by the main sequence while the unit is idle
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_kick     = 1'b0;       // toggled to start one long receiver hold-off
    logic hold_seen     = 1'b0;
    int   hold_left     = 0;
    int   quiet_cycles  = 0;

    function automatic void line_clear();
        words_taken = 0;
        line_zero   = 1'b1;
        lead_word   = 64'd0;
        same8       = 1'b1;
        same4       = 1'b1;
        base_set    = '0;
        fits        = '1;
        for (int k = 0; k < DELTA_CASES; k++) base_of[k] = 64'd0;
        pattern_sum = 8'd0;
    endfunction

    // |a - b| of the 64-bit two's complement difference
    function automatic logic [63:0] distance64(logic [63:0] a, logic [63:0] b);
        logic [63:0] d;
        d = a - b;
        return d[63] ? 64'd0 - d : d;
    endfunction

    // One element into base-delta case k: the first element out of reach of
    // zero becomes the second base; anything out of reach of both fails the case.
    function automatic void fold_element(int k, logic [63:0] v);
        logic near;
        near = distance64(64'd0, v) <= SPAN_LIMIT[k];
        if (!base_set[k] && !near) begin
            base_set[k] = 1'b1;
            base_of[k]  = v;
        end
        if (!near && !(base_set[k] && distance64(base_of[k], v) <= SPAN_LIMIT[k]))
            fits[k] = 1'b0;
    endfunction

    // FPC bytes for one 32-bit word, first matching pattern wins
    function automatic int pattern_bytes(logic [31:0] v);
        logic [31:0] mag;
        mag = v[31] ? 32'd0 - v : v;
        if (v == 32'd0)                                  return 1;
        if (mag <= 32'h0000_00FF)                        return 1;
        if (mag <= 32'h0000_FFFF)                        return 2;
        if (v[15:0] == 16'd0)                            return 2;
        if (v[15:0] <= 16'h00FF && v[31:16] <= 16'h00FF) return 2;
        if (v[15:8] == v[7:0] && v[23:16] == v[7:0] && v[31:24] == v[7:0])
            return 1;
        return 4;
    endfunction

    function automatic int bdi_bytes();
        int best;
        int sz;
        best = LINE_BYTES;
        if (line_zero) best = 1;
        if (same8 && best > 8) best = 8;
        if (same4 && best > 4) best = 4;
        for (int k = 0; k < DELTA_CASES; k++) begin
            sz = fits[k] ? DELTA_BYTES[k] * (LINE_BYTES / ELEM_BYTES[k]) + 2 * ELEM_BYTES[k]
                         : LINE_BYTES;
            if (sz < best) best = sz;
        end
        return best;
    endfunction

    function automatic int fpc_bytes();
        int sz;
        sz = pattern_sum + LINE_HALVES * 3 / 8;   // 3-bit tag per 32-bit word
        return sz < LINE_BYTES ? sz : LINE_BYTES;
    endfunction

    // Folds one accepted word into the line checks. Returns 1 on the last word
    // of a line, with the size picked by the mode in force.
    function automatic logic track_word(logic [63:0] w, output logic [7:0] size);
        logic [31:0] lo;
        logic [31:0] hi;
        int          bdi;
        int          fpc;
        int          pick;
        lo = w[31:0];
        hi = w[63:32];
        if (words_taken == 0) lead_word = w;
        if (w != 64'd0) line_zero = 1'b0;
        if (w != lead_word) same8 = 1'b0;
        if (lo != lead_word[31:0] || hi != lead_word[31:0]) same4 = 1'b0;
        for (int k = 0; k < 3; k++) fold_element(k, w);
        for (int k = 3; k < 5; k++) begin
            fold_element(k, {32'd0, lo});
            fold_element(k, {32'd0, hi});
        end
        for (int j = 0; j < 4; j++) fold_element(5, {48'd0, w[16*j +: 16]});
        pattern_sum = 8'(pattern_sum + pattern_bytes(lo) + pattern_bytes(hi));
        size = 8'd0;
        if (words_taken + 1 < LINE_WORDS) begin
            words_taken++;
            return 1'b0;
        end
        bdi = bdi_bytes();
        fpc = fpc_bytes();
        case (mode_shadow)
            clcs_pkg::MODE_NONE: pick = LINE_BYTES;
            clcs_pkg::MODE_BDI:  pick = bdi;
            clcs_pkg::MODE_FPC:  pick = fpc;
            default:             pick = bdi <= fpc ? bdi : fpc;
        endcase
        size = pick[7:0];
        line_clear();
        return 1'b1;
    endfunction

    initial line_clear();

    // ------------------------------------------------------------------
    // Random line content
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // delta magnitude biased toward zero and the exact limit
    function automatic logic [63:0] delta_span(logic [63:0] lim);
        case ($urandom_range(3))
            0:       return lim;
            1:       return 64'd0;
            2:       return rand64() & lim;
            default: return rand64() & (lim >> 4);
        endcase
    endfunction

    function automatic logic [LINE_BITS-1:0] random_line();
        logic [LINE_BITS-1:0] line;
        logic [LINE_BITS-1:0] ext;
        logic [63:0]          lim;
        logic [63:0]          base;
        logic [63:0]          mask;
        logic [63:0]          mag;
        logic [63:0]          v;
        logic [31:0]          half;
        int                   elem;
        logic                 clean;
        line = '0;
        case ($urandom_range(11))
            0: ;  // all-zero line
            1: begin  // all 8-byte elements equal
                v = rand64();
                for (int w = 0; w < LINE_WORDS; w++) line[w*64 +: 64] = v;
            end
            2: begin  // all 4-byte elements equal
                half = $urandom;
                for (int h = 0; h < LINE_HALVES; h++) line[h*32 +: 32] = half;
            end
            3, 4, 5, 6, 7: begin
                // base plus small deltas, mixed with near-zero elements;
                // a noisy line also throws in out-of-reach elements
                case ($urandom_range(5))
                    0:       begin elem = 8; lim = 64'h0000_0000_0000_00FF; end
                    1:       begin elem = 8; lim = 64'h0000_0000_0000_FFFF; end
                    2:       begin elem = 8; lim = 64'h0000_0000_FFFF_FFFF; end
                    3:       begin elem = 4; lim = 64'h0000_0000_0000_00FF; end
                    4:       begin elem = 4; lim = 64'h0000_0000_0000_FFFF; end
                    default: begin elem = 2; lim = 64'h0000_0000_0000_00FF; end
                endcase
                mask  = (elem == 8) ? '1 : (64'd1 << (elem * 8)) - 64'd1;
                base  = rand64() & mask;
                clean = $urandom_range(9) < 7;
                for (int e = 0; e < LINE_BYTES / elem; e++) begin
                    mag = delta_span(lim);
                    case ($urandom_range(clean ? 7 : 9))
                        0, 1:    v = ($urandom_range(1) && elem == 8) ? 64'd0 - mag : mag;
                        8:       v = base + lim + 64'd1;
                        9:       v = rand64();
                        default: v = $urandom_range(1) ? base + mag : base - mag;
                    endcase
                    ext  = LINE_BITS'(v & mask);
                    line = line | (ext << (e * elem * 8));
                end
            end
            8, 9, 10: begin  // frequent-pattern words
                for (int h = 0; h < LINE_HALVES; h++) begin
                    half = $urandom;
                    case ($urandom_range(7))
                        0: half = 32'd0;
                        1: begin
                            half = $urandom_range(255);
                            if ($urandom_range(1)) half = 32'd0 - half;
                        end
                        2: begin
                            half = $urandom_range(65535);
                            if ($urandom_range(1)) half = 32'd0 - half;
                        end
                        3: half = half << 16;
                        4: half = half & 32'h00FF_00FF;
                        5: half = {4{half[7:0]}};
                        6: ;
                        default: begin
                            case ($urandom_range(3))
                                0:       half = 32'h8000_0000;
                                1:       half = 32'hFFFF_FF00;
                                2:       half = 32'h0001_0000;
                                default: half = 32'h0000_0100;
                            endcase
                        end
                    endcase
                    line[h*32 +: 32] = half;
                end
            end
            default: begin
                for (int w = 0; w < LINE_WORDS; w++) line[w*64 +: 64] = rand64();
            end
        endcase
        return line;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offers one word, idling first at the current rate, and holds it until
    // the transfer. A typed size overrides the predicted one.
    task automatic send_word(logic [63:0] w, logic typed, logic [7:0] typed_size);
        logic [7:0] size;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_line_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        if (track_word(w, size))
            expected_sizes.insert(expected_sizes.size(), typed ? typed_size : size);
    endtask

    // Stops offering and waits until every line in flight has come out.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_sizes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup phase, access phase, then psel is dropped before returning
    // so that back-to-back writes never lower and raise psel in one step.
    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == MODE_ADDR) mode_shadow = clcs_pkg::t_mode'(data[1:0]);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: check each size transfer, then pick the next stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [7:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_sizes.size() == 0) begin
                $error("compressed_bytes: no line pending, actual %0d", o_compressed_bytes);
                failures++;
            end else begin
                want = expected_sizes.pop_front();
                if (o_compressed_bytes !== want) begin
                    $error("compressed_bytes mismatch: expected %0d, actual %0d",
                           want, o_compressed_bytes);
                    failures++;
                end
            end
        end
        // long hold-off, counted here so the sender keeps offering meanwhile
        if (hold_kick != hold_seen) begin
            hold_seen = hold_kick;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transfer means the unit is stuck
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [LINE_BITS-1:0] line;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A write to the spare address must leave the mode at its reset
        // value; the all-zero line below then still reads 1 byte.
        write_reg(SPARE_ADDR, 32'hFFFF_FFFC);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (r % LINE_WORDS == 0 && DIRECTED[r].mode != mode_shadow) begin
                settle();
                write_reg(MODE_ADDR, {30'd0, DIRECTED[r].mode});
            end
            send_word(DIRECTED[r].word, DIRECTED[r].typed, DIRECTED[r].size);
        end

        // Random lines: each phase sets the idle rates, each segment a mode
        // (all four per phase). Segment starts wait for the unit to drain.
        for (int phase = 0; phase < PHASES; phase++) begin
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                settle();
                send_idle_pct = SEND_IDLE_PCT[phase];
                recv_idle_pct = RECV_IDLE_PCT[phase];
                write_reg(MODE_ADDR, {30'($urandom),
                                      clcs_pkg::t_mode'(2'((seg + phase) % 4))});
                if ($urandom_range(1)) write_reg(SPARE_ADDR, $urandom);
                // fill the unit against a stalled output, once with idling, once without
                if (seg == 1 && phase != 1) hold_kick <= ~hold_kick;
                for (int n = 0; n < SEGMENT_LINES; n++) begin
                    line = random_line();
                    for (int w = 0; w < LINE_WORDS; w++)
                        send_word(line[w*64 +: 64], 1'b0, 8'd0);
                end
            end
        end

        settle();
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
